[hdl/kde_pkg.sv]
`default_nettype none

package kde_pkg;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned VALUE_W = 30;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned CFG_W   = 4;

  // Key codes and echo characters (ASCII).
  localparam logic [KEY_W-1:0] KEY_CANCEL = 8'h63;  // 'c'
  localparam logic [KEY_W-1:0] KEY_DELETE = 8'h44;  // 'D'
  localparam logic [KEY_W-1:0] KEY_ENTER  = 8'h3D;  // '='
  localparam logic [KEY_W-1:0] CHAR_MASK  = 8'h2A;  // '*'
  localparam logic [KEY_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [KEY_W-1:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [KEY_W-1:0] CHAR_NONE  = 8'h00;

  // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP10) >> RECIP10_SHIFT.
  localparam logic [31:0]  RECIP10       = 32'hCCCC_CCCD;
  localparam int unsigned  RECIP10_SHIFT = 35;

  // Configuration register indexes.
  localparam logic REG_MAX_DIGITS = 1'b0;
  localparam logic REG_MASK_ECHO  = 1'b1;

  localparam logic [COUNT_W-1:0] MAX_DIGITS_RST = 4'd4;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_PRINT = 2'd1,
    ACT_ERASE = 2'd2
  } echo_act_t;

  typedef struct packed {
    echo_act_t           echo_action;
    logic [KEY_W-1:0]    echo_char;
    logic                entry_done;
    logic                cancelled;
    logic [VALUE_W-1:0]  entry_value;
    logic [COUNT_W-1:0]  digit_count;
  } kde_result_t;

endpackage

`default_nettype wire

[hdl/kde_step.sv]
`default_nettype none

module kde_step #(
  parameter int unsigned DIGIT_LIMIT = 9
) (
  input  wire logic [kde_pkg::KEY_W-1:0]   key_code,
  input  wire logic [kde_pkg::CFG_W-1:0]   max_digits,
  input  wire logic                        mask_echo,
  input  wire logic [kde_pkg::VALUE_W-1:0] value_cur,
  input  wire logic [kde_pkg::COUNT_W-1:0] count_cur,
  output kde_pkg::kde_result_t             result,
  output logic      [kde_pkg::VALUE_W-1:0] value_nxt,
  output logic      [kde_pkg::COUNT_W-1:0] count_nxt
);
  import kde_pkg::*;

  localparam logic [COUNT_W-1:0] LIMIT_CAP = COUNT_W'(DIGIT_LIMIT);

  logic [COUNT_W-1:0]  limit;
  logic [VALUE_W+3:0]  append_wide;
  logic [VALUE_W-1:0]  value_append;
  logic [61:0]         recip_prod;
  logic [VALUE_W-1:0]  value_drop;
  logic [VALUE_W-1:0]  value_new;
  logic [COUNT_W-1:0]  count_new;
  logic                is_digit;

  assign limit = (max_digits < LIMIT_CAP) ? max_digits : LIMIT_CAP;

  // value * 10 + digit, as two shifts and two adds.
  assign append_wide  = {1'b0, value_cur, 3'b000} + {3'b000, value_cur, 1'b0}
                      + {(VALUE_W+4-4)'(0), 4'(key_code - CHAR_ZERO)};
  assign value_append = append_wide[VALUE_W-1:0];

  // value / 10 by reciprocal multiply; exact for any 30-bit dividend.
  assign recip_prod = value_cur * RECIP10;
  assign value_drop = VALUE_W'(recip_prod[61:RECIP10_SHIFT]);

  always_comb begin
    is_digit = key_code inside {[CHAR_ZERO:CHAR_NINE]};

    result.echo_action = ACT_NONE;
    result.echo_char   = CHAR_NONE;
    result.entry_done  = 1'b0;
    result.cancelled   = 1'b0;
    value_new          = value_cur;
    count_new          = count_cur;

    if (key_code == KEY_CANCEL) begin
      result.entry_done = 1'b1;
      result.cancelled  = 1'b1;
      value_new         = '0;
      count_new         = '0;
    end else if (key_code == KEY_DELETE) begin
      if (count_cur != '0) begin
        count_new          = count_cur - 1'b1;
        value_new          = value_drop;
        result.echo_action = ACT_ERASE;
      end
    end else if (count_cur < limit) begin
      if (is_digit) begin
        value_new          = value_append;
        count_new          = count_cur + 1'b1;
        result.echo_action = ACT_PRINT;
        result.echo_char   = mask_echo ? CHAR_MASK : key_code;
      end
    end else if (key_code == KEY_ENTER && count_cur == limit) begin
      result.entry_done = 1'b1;
    end

    result.entry_value = value_new;
    result.digit_count = count_new;

    value_nxt = result.entry_done ? '0 : value_new;
    count_nxt = result.entry_done ? '0 : count_new;
  end

endmodule

`default_nettype wire

[hdl/keypad_decimal_entry_editor.sv]
// Keypad decimal entry editor.
//
// Input channel: one ASCII key code per transfer on in_key_code (in_valid /
// in_ready). Output channel: exactly one result per key on the out_ ports
// (out_valid / out_ready): an echo action for the display, the echo
// character, end-of-entry and cancel flags, and the running value and digit
// count after the key.
// A key taken at a clock edge is registered in the input register, evaluated
// against the held entry state, and its result is registered in the output
// register, which presents it on the out_ ports. Throughput is one key per
// cycle while the receiver does not stall; the input register and the output
// register form a two-stage pipeline, and the held state is updated as each
// key is evaluated, so back-to-back keys see each other's effect.
// When the receiver stalls, the result stays in the output register and the
// key in the input register waits; in_ready drops only when both are full and
// out_ready is low. Configuration (cfg_we, cfg_index, cfg_wdata) writes
// max_digits (index 0) or mask_echo (index 1) and should be done only while no
// key is in flight. Synchronous reset clears the entry state and both valid
// flags and restores max_digits to 4 and mask_echo to 0. No memory is used.
`default_nettype none

module keypad_decimal_entry_editor #(
  parameter int unsigned DIGIT_LIMIT = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [kde_pkg::KEY_W-1:0]     in_key_code,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [1:0]                    out_echo_action,
  output logic      [kde_pkg::KEY_W-1:0]     out_echo_char,
  output logic                               out_entry_done,
  output logic                               out_cancelled,
  output logic      [kde_pkg::VALUE_W-1:0]   out_entry_value,
  output logic      [kde_pkg::COUNT_W-1:0]   out_digit_count,

  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [kde_pkg::CFG_W-1:0]     cfg_wdata
);
  import kde_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0]   max_digits_r;
  logic               mask_echo_r;

  // Input stage.
  logic               key_vld_r;
  logic [KEY_W-1:0]   key_r;

  // Held entry state.
  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] value_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;

  // Output stage.
  logic               out_vld_r;
  kde_result_t        res_r;
  kde_result_t        res_nxt;

  logic               advance;

  // The key in the input register is evaluated when the output register is
  // empty or its result is transferred in this same cycle.
  assign advance  = key_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !key_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_digits_r <= MAX_DIGITS_RST;
      mask_echo_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_DIGITS: max_digits_r <= cfg_wdata;
        REG_MASK_ECHO:  mask_echo_r  <= cfg_wdata[0];
        default:        max_digits_r <= max_digits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= 1'b0;
    end else if (in_ready) begin
      key_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r <= in_key_code;
    end
  end

  kde_step #(
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_step (
    .key_code   (key_r),
    .max_digits (max_digits_r),
    .mask_echo  (mask_echo_r),
    .value_cur  (value_r),
    .count_cur  (count_r),
    .result     (res_nxt),
    .value_nxt  (value_nxt),
    .count_nxt  (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      count_r <= '0;
    end else if (advance) begin
      value_r <= value_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_echo_action = res_r.echo_action;
  assign out_echo_char   = res_r.echo_char;
  assign out_entry_done  = res_r.entry_done;
  assign out_cancelled   = res_r.cancelled;
  assign out_entry_value = res_r.entry_value;
  assign out_digit_count = res_r.digit_count;

`ifndef SYNTHESIS
  // A cancel result always reports an ended, empty entry.
  a_cancel_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.cancelled) |->
      (res_r.entry_done && res_r.entry_value == '0 && res_r.digit_count == '0))
    else $error("cancel result does not report an empty ended entry");

  // A printed digit means at least one digit is now held.
  a_print_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.echo_action == ACT_PRINT) |-> (res_r.digit_count != '0))
    else $error("print echo with zero digits held");

  // After a key ends the entry, the held state is empty for the next key.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.entry_done) |=> (value_r == '0 && count_r == '0))
    else $error("entry state not cleared after end of entry");

  // With no digits held, the held value is zero.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (value_r == '0))
    else $error("nonzero value with no digits held");
`endif

endmodule

`default_nettype wire

[verif/keypad_entry_checker.sv]
// Watches both channels of the keypad entry editor, keeps its own copy of
// the entry state and the configuration, and compares each result transfer
// with the oldest predicted result.
module keypad_entry_checker #(
  parameter int unsigned DIGIT_LIMIT = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [kde_pkg::KEY_W-1:0]     in_key_code,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    out_echo_action,
  input  logic [kde_pkg::KEY_W-1:0]     out_echo_char,
  input  logic                          out_entry_done,
  input  logic                          out_cancelled,
  input  logic [kde_pkg::VALUE_W-1:0]   out_entry_value,
  input  logic [kde_pkg::COUNT_W-1:0]   out_digit_count,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [kde_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import kde_pkg::*;

  logic [VALUE_W-1:0] number_so_far;
  logic [COUNT_W-1:0] digits_held;
  logic [COUNT_W-1:0] width_setting;
  logic               masked;
  kde_result_t        awaited_results[$];
  int                 errors = 0;
  int                 waiting = 0;

  assign fail_count = errors;
  assign pending    = waiting;

  // Applies one key to the entry and returns what the display should see.
  function automatic kde_result_t press_key(input logic [KEY_W-1:0] key);
    kde_result_t        res;
    logic [COUNT_W-1:0] limit;
    limit = (width_setting > DIGIT_LIMIT) ? COUNT_W'(DIGIT_LIMIT) : width_setting;
    res = '0;
    res.echo_action = ACT_NONE;
    if (key == KEY_CANCEL) begin
      res.entry_done = 1'b1;
      res.cancelled  = 1'b1;
      number_so_far  = '0;
      digits_held    = '0;
    end else if (key == KEY_DELETE) begin
      if (digits_held != 0) begin
        digits_held     = digits_held - 1'b1;
        number_so_far   = VALUE_W'(number_so_far / 10);
        res.echo_action = ACT_ERASE;
      end
    end else if (digits_held < limit) begin
      if (key >= CHAR_ZERO && key <= CHAR_NINE) begin
        number_so_far   = number_so_far * 30'd10 + VALUE_W'(key - CHAR_ZERO);
        digits_held     = digits_held + 1'b1;
        res.echo_action = ACT_PRINT;
        res.echo_char   = masked ? CHAR_MASK : key;
      end
    end else if (key == KEY_ENTER && digits_held == limit) begin
      res.entry_done = 1'b1;
    end
    res.entry_value = number_so_far;
    res.digit_count = digits_held;
    if (res.entry_done) begin
      number_so_far = '0;
      digits_held   = '0;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    kde_result_t want;
    if (!rst_n) begin
      number_so_far = '0;
      digits_held   = '0;
      width_setting = MAX_DIGITS_RST;
      masked        = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_DIGITS: width_setting = cfg_wdata;
          REG_MASK_ECHO:  masked = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(press_key(in_key_code));
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, expected none, actual %0d",
                   $time, out_entry_value);
        end else begin
          want = awaited_results.pop_front();
          check_field("echo_action", 32'(want.echo_action), 32'(out_echo_action));
          check_field("echo_char", 32'(want.echo_char), 32'(out_echo_char));
          check_field("entry_done", 32'(want.entry_done), 32'(out_entry_done));
          check_field("cancelled", 32'(want.cancelled), 32'(out_cancelled));
          check_field("entry_value", 32'(want.entry_value), 32'(out_entry_value));
          check_field("digit_count", 32'(want.digit_count), 32'(out_digit_count));
        end
      end
    end
    waiting <= awaited_results.size();
  end

endmodule

[verif/tb.sv]
// Top of the keypad entry editor testbench. It makes the clock, the reset,
// the key stream, the receiver stalls and the register writes. All checking
// lives in the checker instance; this module only gives the verdict.
module tb;
  import kde_pkg::*;

  localparam int unsigned DIGIT_LIMIT = 9;
  localparam int unsigned PHASES = 10;
  localparam int unsigned KEYS_PER_PHASE = 130;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KEY_W-1:0]     in_key_code = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [1:0]           out_echo_action;
  logic [KEY_W-1:0]     out_echo_char;
  logic                 out_entry_done;
  logic                 out_cancelled;
  logic [VALUE_W-1:0]   out_entry_value;
  logic [COUNT_W-1:0]   out_digit_count;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = REG_MAX_DIGITS;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   fail_count;
  int                   pending;

  // When idle_on is clear, neither side inserts gaps, so the block runs at
  // full rate. A nonzero squeeze asks the receiver for one long stall.
  int                   idle_on = 1;
  int                   squeeze = 0;

  keypad_decimal_entry_editor #(.DIGIT_LIMIT(DIGIT_LIMIT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_key_code(in_key_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_echo_action(out_echo_action), .out_echo_char(out_echo_char),
    .out_entry_done(out_entry_done), .out_cancelled(out_cancelled),
    .out_entry_value(out_entry_value), .out_digit_count(out_digit_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  keypad_entry_checker #(.DIGIT_LIMIT(DIGIT_LIMIT)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_key_code(in_key_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_echo_action(out_echo_action), .out_echo_char(out_echo_char),
    .out_entry_done(out_entry_done), .out_cancelled(out_cancelled),
    .out_entry_value(out_entry_value), .out_digit_count(out_digit_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one key and returns at the edge where the transfer happens. With
  // no gap, valid simply stays high into the next key, so it is never lowered
  // and raised again within one step.
  task automatic send_key(input logic [KEY_W-1:0] key);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_key_code <= key;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string digits);
    for (int i = 0; i < digits.len(); i++) begin
      send_key(digits[i]);
    end
  endtask

  // Drops valid, waits for every predicted result to come out, and then lets
  // the block idle before returning, so that it is fully drained.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; the enable stays high across
  // the pair and drops once at the end.
  task automatic set_config(input logic [CFG_W-1:0] digits_setting,
                            input logic [CFG_W-1:0] mask_data);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_DIGITS;
    cfg_wdata <= digits_setting;
    @(posedge clk);
    cfg_index <= REG_MASK_ECHO;
    cfg_wdata <= mask_data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly digits so that entries fill up, with enough deletes, enters and
  // cancels to walk through every state, and some arbitrary codes as noise.
  function automatic logic [KEY_W-1:0] random_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return CHAR_ZERO + KEY_W'($urandom_range(0, 9));
    if (pick < 67) return KEY_DELETE;
    if (pick < 80) return KEY_ENTER;
    if (pick < 86) return KEY_CANCEL;
    return KEY_W'($urandom_range(0, 255));
  endfunction

  // The receiver draws a stall for each result. When a squeeze is requested
  // it holds ready low for one long stall while the sender keeps offering
  // keys, which fills both pipeline registers and pushes back on the input.
  initial begin
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (squeeze > 0) begin
        stall   = squeeze;
        squeeze = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #2000000;
    $display("keypad_decimal_entry_editor verification failed");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] digits_setting;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, four digits unmasked: enter and delete on an empty
    // entry are ignored, a digit past the limit is ignored, enter on a full
    // entry finishes it.
    send_key(KEY_ENTER);
    send_key(KEY_DELETE);
    send_text("90095");
    send_key(KEY_ENTER);
    settle();

    // Masked echo, a delete of a typed digit, keys outside the keypad set,
    // and a cancel partway through an entry.
    set_config(4'd4, 4'd1);
    send_text("1");
    send_key(KEY_DELETE);
    send_text("8");
    send_key(8'h00);
    send_key(8'hFF);
    send_key(KEY_CANCEL);
    settle();

    // A limit of zero takes no digit, so enter finishes at once with zero.
    set_config(4'd0, 4'd0);
    send_key(KEY_ENTER);
    settle();

    // A limit above the parameter is clipped to nine digits, the widest
    // value the block carries.
    set_config(4'd15, 4'd0);
    send_text("999999999");
    settle();

    // Lowering the limit under a held entry: digits and enter are refused
    // until deletes bring the count back down to the new limit.
    set_config(4'd7, 4'd0);
    send_text("0");
    send_key(KEY_ENTER);
    send_key(KEY_DELETE);
    send_key(KEY_DELETE);
    send_key(KEY_ENTER);
    settle();

    // Random phases. The first few take the extreme limits, the rest draw
    // one at random; the mask bit alternates and its upper data bits are
    // random. Every fourth phase runs without gaps.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       digits_setting = 4'd0;
        1:       digits_setting = 4'd9;
        2:       digits_setting = 4'd15;
        3:       digits_setting = 4'd1;
        default: digits_setting = CFG_W'($urandom_range(0, 15));
      endcase
      set_config(digits_setting, {3'($urandom_range(0, 7)), 1'(p % 2)});
      idle_on = (p % 4 != 3);
      if (p == 2 || p == 6) squeeze = 60;
      for (int k = 0; k < KEYS_PER_PHASE; k++) begin
        send_key(random_key());
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("keypad_decimal_entry_editor verification clean");
    end else begin
      $display("keypad_decimal_entry_editor verification failed");
    end
    $finish;
  end

endmodule
